// File: hw/rtl/jac_pkg.sv
// shared constants and register index codes for the joystick axis calibrator
// no dependencies
`timescale 1ns / 1ps

package jac_pkg;

  localparam int OUT_W      = 16;
  localparam int Q_BITS     = OUT_W - 1;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = Q_BITS / DIV_STEP;
  localparam int DZ_W       = 12;
  localparam int CFG_IDX_W  = 3;

  localparam int CAL_CENTER_RESET = 512;
  localparam int CAL_NSPAN_RESET  = 511;
  localparam int CAL_PSPAN_RESET  = 511;
  localparam int DZ_RESET         = 164;
  localparam int PRESS_RESET      = 900;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_H    = 3'd0,
    CFG_LEFT_V    = 3'd1,
    CFG_RIGHT_H   = 3'd2,
    CFG_RIGHT_V   = 3'd3,
    CFG_BYPASS    = 3'd4,
    CFG_DEAD_ZONE = 3'd5,
    CFG_PRESS_THR = 3'd6
  } cfg_idx_e;

endpackage

// File: hw/rtl/joystick_axis_calibrator.sv
// joystick axis calibrator, top level: config registers, stage valids and lanes
// pipeline: front stages, divider stages and result stages lie between an accepted word and out_valid_o
// throughput: one word per cycle unless out_stall_i holds the pipeline, set by the fully pipelined 15-bit divider
// reset clears stage valids and loads the config reset values; no clearing pass
// depends on jac_pkg, jac_front, jac_div_step, jac_result
`timescale 1ns / 1ps

module joystick_axis_calibrator import jac_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [3*SAMPLE_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SAMPLE_BITS-1:0]   left_horizontal_raw_i,
  input  logic [SAMPLE_BITS-1:0]   left_vertical_raw_i,
  input  logic [SAMPLE_BITS-1:0]   right_horizontal_raw_i,
  input  logic [SAMPLE_BITS-1:0]   right_vertical_raw_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OUT_W-1:0]  left_x_o,
  output logic signed [OUT_W-1:0]  left_y_o,
  output logic                     left_pressed_o,
  output logic signed [OUT_W-1:0]  right_x_o,
  output logic signed [OUT_W-1:0]  right_y_o,
  output logic                     right_pressed_o
);

  localparam int CAL_W = 3 * SAMPLE_BITS;
  localparam int NST   = DIV_STAGES + 4;
  localparam logic [CAL_W-1:0] CAL_RESET_V = {SAMPLE_BITS'(CAL_PSPAN_RESET),
                                              SAMPLE_BITS'(CAL_NSPAN_RESET),
                                              SAMPLE_BITS'(CAL_CENTER_RESET)};

  logic [CAL_W-1:0]       cal_q [4];
  logic                   bypass_q;
  logic [DZ_W-1:0]        dz_q;
  logic [SAMPLE_BITS-1:0] press_q;

  logic [NST-1:0]         valid_q;
  logic [NST-1:0]         adv;
  logic [1:0]             pressed_q [NST];
  logic [1:0]             pressed_d;

  logic [SAMPLE_BITS-1:0] raw [4];

  logic                   neg_s  [DIV_STAGES+1][4];
  logic [SAMPLE_BITS-1:0] mag_s  [DIV_STAGES+1][4];
  logic [SAMPLE_BITS-1:0] span_s [DIV_STAGES+1][4];
  logic [SAMPLE_BITS-1:0] rem_s  [DIV_STAGES+1][4];
  logic [Q_BITS-1:0]      q_s    [DIV_STAGES+1][4];
  logic                   ovf_s  [DIV_STAGES+1][4];

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        cal_q[i] <= CAL_RESET_V;
      end
      bypass_q <= 1'b0;
      dz_q     <= DZ_W'(DZ_RESET);
      press_q  <= SAMPLE_BITS'(PRESS_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT_H:    cal_q[0] <= cfg_data_i;
        CFG_LEFT_V:    cal_q[1] <= cfg_data_i;
        CFG_RIGHT_H:   cal_q[2] <= cfg_data_i;
        CFG_RIGHT_V:   cal_q[3] <= cfg_data_i;
        CFG_BYPASS:    bypass_q <= cfg_data_i[0];
        CFG_DEAD_ZONE: dz_q     <= cfg_data_i[DZ_W-1:0];
        CFG_PRESS_THR: press_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage advance: a stage loads when empty or when its successor moves on
  always_comb begin
    adv[NST-1] = !valid_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // press flags ride a shift line alongside the axis lanes
  assign pressed_d = {right_vertical_raw_i > press_q, left_vertical_raw_i > press_q};

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pressed_q[0] <= pressed_d;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        pressed_q[k] <= pressed_q[k-1];
      end
    end
  end

  assign left_pressed_o  = pressed_q[NST-1][0];
  assign right_pressed_o = pressed_q[NST-1][1];

  assign raw[0] = left_horizontal_raw_i;
  assign raw[1] = left_vertical_raw_i;
  assign raw[2] = right_horizontal_raw_i;
  assign raw[3] = right_vertical_raw_i;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    jac_front #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .NEGATE     (l % 2 == 0)
    ) u_front (
      .clk_i (clk_i),
      .en1_i (adv[0]),
      .en2_i (adv[1]),
      .raw_i (raw[l]),
      .cal_i (cal_q[l]),
      .neg_o (neg_s[0][l]),
      .mag_o (mag_s[0][l]),
      .span_o(span_s[0][l]),
      .rem_o (rem_s[0][l]),
      .ovf_o (ovf_s[0][l])
    );

    assign q_s[0][l] = '0;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      jac_div_step #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .STAGE      (s)
      ) u_step (
        .clk_i (clk_i),
        .en_i  (adv[2+s]),
        .neg_i (neg_s[s][l]),
        .mag_i (mag_s[s][l]),
        .span_i(span_s[s][l]),
        .rem_i (rem_s[s][l]),
        .q_i   (q_s[s][l]),
        .ovf_i (ovf_s[s][l]),
        .neg_o (neg_s[s+1][l]),
        .mag_o (mag_s[s+1][l]),
        .span_o(span_s[s+1][l]),
        .rem_o (rem_s[s+1][l]),
        .q_o   (q_s[s+1][l]),
        .ovf_o (ovf_s[s+1][l])
      );
    end
  end

  jac_result #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_left (
    .clk_i      (clk_i),
    .en_a_i     (adv[NST-2]),
    .en_b_i     (adv[NST-1]),
    .bypass_i   (bypass_q),
    .dead_zone_i(dz_q),
    .x_neg_i    (neg_s[DIV_STAGES][0]),
    .x_mag_i    (mag_s[DIV_STAGES][0]),
    .x_q_i      (q_s[DIV_STAGES][0]),
    .x_ovf_i    (ovf_s[DIV_STAGES][0]),
    .y_neg_i    (neg_s[DIV_STAGES][1]),
    .y_mag_i    (mag_s[DIV_STAGES][1]),
    .y_q_i      (q_s[DIV_STAGES][1]),
    .y_ovf_i    (ovf_s[DIV_STAGES][1]),
    .x_o        (left_x_o),
    .y_o        (left_y_o)
  );

  jac_result #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_right (
    .clk_i      (clk_i),
    .en_a_i     (adv[NST-2]),
    .en_b_i     (adv[NST-1]),
    .bypass_i   (bypass_q),
    .dead_zone_i(dz_q),
    .x_neg_i    (neg_s[DIV_STAGES][2]),
    .x_mag_i    (mag_s[DIV_STAGES][2]),
    .x_q_i      (q_s[DIV_STAGES][2]),
    .x_ovf_i    (ovf_s[DIV_STAGES][2]),
    .y_neg_i    (neg_s[DIV_STAGES][3]),
    .y_mag_i    (mag_s[DIV_STAGES][3]),
    .y_q_i      (q_s[DIV_STAGES][3]),
    .y_ovf_i    (ovf_s[DIV_STAGES][3]),
    .x_o        (right_x_o),
    .y_o        (right_y_o)
  );

`ifndef SYNTH
  // input only stalls when every stage holds a word and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled with a free stage");

  // a taken output with an empty stage behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !valid_q[NST-2]) |=> !out_valid_o)
    else $error("output word repeated");

  // a fresh output word always comes from the stage before it
  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !valid_q[NST-2]) |=> !out_valid_o)
    else $error("output word invented");
`endif

endmodule

// File: hw/rtl/jac_front.sv
// first two pipeline stages of one axis: centring, sign and span select,
// then the divider overflow check; uses jac_pkg
`timescale 1ns / 1ps

module jac_front import jac_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 12,
  parameter bit NEGATE      = 1'b0
) (
  input  logic                     clk_i,
  input  logic                     en1_i,
  input  logic                     en2_i,
  input  logic [SAMPLE_BITS-1:0]   raw_i,
  input  logic [3*SAMPLE_BITS-1:0] cal_i,
  output logic                     neg_o,
  output logic [SAMPLE_BITS-1:0]   mag_o,
  output logic [SAMPLE_BITS-1:0]   span_o,
  output logic [SAMPLE_BITS-1:0]   rem_o,
  output logic                     ovf_o
);

  logic [SAMPLE_BITS-1:0] center, nspan, pspan, span_sel;
  logic                   neg1_d, neg1_q;
  logic [SAMPLE_BITS-1:0] mag1_d, mag1_q, span1_q;
  logic [SAMPLE_BITS-1:0] r0;

  assign center = cal_i[SAMPLE_BITS-1:0];
  assign nspan  = cal_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign pspan  = cal_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  // horizontal axes read negated
  always_comb begin
    if (NEGATE) begin
      neg1_d = raw_i > center;
    end else begin
      neg1_d = raw_i < center;
    end
    mag1_d   = (raw_i >= center) ? (raw_i - center) : (center - raw_i);
    span_sel = neg1_d ? nspan : pspan;
    if (span_sel == '0) begin
      span_sel = SAMPLE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      neg1_q  <= neg1_d;
      mag1_q  <= mag1_d;
      span1_q <= span_sel;
    end
  end

  // top of the shifted dividend; the quotient overflows when it reaches the span
  assign r0 = mag1_q >> (Q_BITS - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      neg_o  <= neg1_q;
      mag_o  <= mag1_q;
      span_o <= span1_q;
      rem_o  <= r0;
      ovf_o  <= r0 >= span1_q;
    end
  end

endmodule

// File: hw/rtl/jac_div_step.sv
// one stage of the pipelined restoring divider, DIV_STEP quotient bits per stage
// uses jac_pkg
`timescale 1ns / 1ps

module jac_div_step import jac_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 12,
  parameter int STAGE       = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic                   neg_i,
  input  logic [SAMPLE_BITS-1:0] mag_i,
  input  logic [SAMPLE_BITS-1:0] span_i,
  input  logic [SAMPLE_BITS-1:0] rem_i,
  input  logic [Q_BITS-1:0]      q_i,
  input  logic                   ovf_i,
  output logic                   neg_o,
  output logic [SAMPLE_BITS-1:0] mag_o,
  output logic [SAMPLE_BITS-1:0] span_o,
  output logic [SAMPLE_BITS-1:0] rem_o,
  output logic [Q_BITS-1:0]      q_o,
  output logic                   ovf_o
);

  localparam int TOP = Q_BITS - 1 - STAGE * DIV_STEP;

  logic [Q_BITS-1:0]      dvd;
  logic [SAMPLE_BITS:0]   r;
  logic [SAMPLE_BITS-1:0] rr;
  logic [Q_BITS-1:0]      qq;

  assign dvd = Q_BITS'({mag_i, {FRAC_BITS{1'b0}}});

  always_comb begin
    rr = rem_i;
    qq = q_i;
    r  = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      r = {rr, dvd[TOP-k]};
      if (r >= {1'b0, span_i}) begin
        r  = r - {1'b0, span_i};
        qq = {qq[Q_BITS-2:0], 1'b1};
      end else begin
        qq = {qq[Q_BITS-2:0], 1'b0};
      end
      rr = r[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o  <= neg_i;
      mag_o  <= mag_i;
      span_o <= span_i;
      rem_o  <= rr;
      q_o    <= qq;
      ovf_o  <= ovf_i;
    end
  end

endmodule

// File: hw/rtl/jac_result.sv
// last two stages of one stick: sign, saturation and bypass select,
// then the dead zone and the output register; uses jac_pkg
`timescale 1ns / 1ps

module jac_result import jac_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    en_a_i,
  input  logic                    en_b_i,
  input  logic                    bypass_i,
  input  logic [DZ_W-1:0]         dead_zone_i,
  input  logic                    x_neg_i,
  input  logic [SAMPLE_BITS-1:0]  x_mag_i,
  input  logic [Q_BITS-1:0]       x_q_i,
  input  logic                    x_ovf_i,
  input  logic                    y_neg_i,
  input  logic [SAMPLE_BITS-1:0]  y_mag_i,
  input  logic [Q_BITS-1:0]       y_q_i,
  input  logic                    y_ovf_i,
  output logic signed [OUT_W-1:0] x_o,
  output logic signed [OUT_W-1:0] y_o
);

  localparam int EW = (SAMPLE_BITS + 1 > OUT_W + 1) ? SAMPLE_BITS + 1 : OUT_W + 1;
  localparam logic signed [EW-1:0]    E_MAX = EW'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [EW-1:0]    E_MIN = -E_MAX - EW'(1);
  localparam logic signed [OUT_W-1:0] O_MAX = OUT_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [OUT_W-1:0] O_MIN = -O_MAX - OUT_W'(1);

  function automatic logic signed [OUT_W-1:0] axis_val(
    input logic                   neg,
    input logic [SAMPLE_BITS-1:0] mag,
    input logic [Q_BITS-1:0]      q,
    input logic                   ovf,
    input logic                   bypass
  );
    logic signed [EW-1:0]    e;
    logic signed [OUT_W-1:0] qs;
    logic signed [OUT_W-1:0] res;
    e  = signed'({{(EW - SAMPLE_BITS){1'b0}}, mag});
    qs = signed'({1'b0, q});
    if (neg) begin
      e  = -e;
      qs = -qs;
    end
    if (bypass) begin
      if (e > E_MAX) begin
        res = O_MAX;
      end else if (e < E_MIN) begin
        res = O_MIN;
      end else begin
        res = e[OUT_W-1:0];
      end
    end else if (ovf) begin
      res = neg ? O_MIN : O_MAX;
    end else begin
      res = qs;
    end
    return res;
  endfunction

  logic signed [OUT_W-1:0] xa_q, ya_q;
  logic [OUT_W:0]          ax, ay;
  logic                    zone;

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      xa_q <= axis_val(x_neg_i, x_mag_i, x_q_i, x_ovf_i, bypass_i);
      ya_q <= axis_val(y_neg_i, y_mag_i, y_q_i, y_ovf_i, bypass_i);
    end
  end

  always_comb begin
    ax   = xa_q[OUT_W-1] ? -{xa_q[OUT_W-1], xa_q} : {xa_q[OUT_W-1], xa_q};
    ay   = ya_q[OUT_W-1] ? -{ya_q[OUT_W-1], ya_q} : {ya_q[OUT_W-1], ya_q};
    zone = !bypass_i && (ax < (OUT_W + 1)'(dead_zone_i))
                     && (ay < (OUT_W + 1)'(dead_zone_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      x_o <= zone ? '0 : xa_q;
      y_o <= zone ? '0 : ya_q;
    end
  end

endmodule

// File: sim/tb.sv
// self-checking bench for joystick_axis_calibrator: a scoreboard class predicts each output word
// from the accepted input word and the register settings, then compares every field
// depends on jac_pkg and joystick_axis_calibrator
`timescale 1ns / 1ps

module tb;
  import jac_pkg::*;

  localparam int SB            = 10;
  localparam int FRAC          = 12;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_WORDS   = 105;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam logic [3*SB-1:0] CAL_DEFAULT =
    {SB'(CAL_PSPAN_RESET), SB'(CAL_NSPAN_RESET), SB'(CAL_CENTER_RESET)};

  typedef struct packed {
    logic [OUT_W-1:0] lx;
    logic [OUT_W-1:0] ly;
    logic             lp;
    logic [OUT_W-1:0] rx;
    logic [OUT_W-1:0] ry;
    logic             rp;
  } pad_word_t;

  class stick_scoreboard;
    logic [3*SB-1:0] cal [4];
    logic            bypass;
    logic [DZ_W-1:0] dead_zone;
    logic [SB-1:0]   press_thr;
    pad_word_t       due_q[$];
    int              errors;

    function new();
      foreach (cal[i]) cal[i] = CAL_DEFAULT;
      bypass    = 1'b0;
      dead_zone = DZ_W'(DZ_RESET);
      press_thr = SB'(PRESS_RESET);
      errors    = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [3*SB-1:0] data);
      case (idx)
        CFG_LEFT_H, CFG_LEFT_V, CFG_RIGHT_H, CFG_RIGHT_V: cal[idx[1:0]] = data;
        CFG_BYPASS:    bypass    = data[0];
        CFG_DEAD_ZONE: dead_zone = data[DZ_W-1:0];
        CFG_PRESS_THR: press_thr = data[SB-1:0];
        default: ;
      endcase
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function int axis(logic [SB-1:0] raw, logic [3*SB-1:0] c, bit flip);
      int offs;
      int span;
      int q;
      offs = int'(raw) - int'(c[SB-1:0]);
      if (flip) offs = -offs;
      if (bypass) return clamp16(offs);
      if (offs == 0) return 0;
      span = (offs < 0) ? int'(c[2*SB-1:SB]) : int'(c[3*SB-1:2*SB]);
      if (span == 0) span = 1;
      q = ((offs < 0 ? -offs : offs) << FRAC) / span;
      if (q > 32768) q = 32768;
      return clamp16(offs < 0 ? -q : q);
    endfunction

    function void stick(logic [SB-1:0] h, logic [SB-1:0] v, logic [3*SB-1:0] hc,
                        logic [3*SB-1:0] vc, output logic [OUT_W-1:0] x,
                        output logic [OUT_W-1:0] y, output logic p);
      int ax;
      int ay;
      ax = axis(h, hc, 1'b1);
      ay = axis(v, vc, 1'b0);
      if (!bypass && (ax < 0 ? -ax : ax) < int'(dead_zone) &&
          (ay < 0 ? -ay : ay) < int'(dead_zone)) begin
        ax = 0;
        ay = 0;
      end
      x = OUT_W'(ax);
      y = OUT_W'(ay);
      p = v > press_thr;
    endfunction

    function void note_word(logic [SB-1:0] lh, logic [SB-1:0] lv,
                            logic [SB-1:0] rh, logic [SB-1:0] rv);
      pad_word_t w;
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic p;
      stick(lh, lv, cal[CFG_LEFT_H], cal[CFG_LEFT_V], x, y, p);
      w.lx = x;
      w.ly = y;
      w.lp = p;
      stick(rh, rv, cal[CFG_RIGHT_H], cal[CFG_RIGHT_V], x, y, p);
      w.rx = x;
      w.ry = y;
      w.rp = p;
      due_q.push_back(w);
    endfunction

    function void check_word(pad_word_t got);
      pad_word_t exp_w;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: lx %0d ly %0d lp %0b rx %0d ry %0d rp %0b",
                   $signed(got.lx), $signed(got.ly), got.lp,
                   $signed(got.rx), $signed(got.ry), got.rp);
        return;
      end
      exp_w = due_q.pop_front();
      if (got.lx !== exp_w.lx || got.ly !== exp_w.ly || got.lp !== exp_w.lp ||
          got.rx !== exp_w.rx || got.ry !== exp_w.ry || got.rp !== exp_w.rp) begin
        errors++;
        if (errors <= 10)
          $display({"word mismatch: expected lx %0d ly %0d lp %0b rx %0d ry %0d rp %0b,",
                    " got lx %0d ly %0d lp %0b rx %0d ry %0d rp %0b"},
                   $signed(exp_w.lx), $signed(exp_w.ly), exp_w.lp,
                   $signed(exp_w.rx), $signed(exp_w.ry), exp_w.rp,
                   $signed(got.lx), $signed(got.ly), got.lp,
                   $signed(got.rx), $signed(got.ry), got.rp);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [3*SB-1:0]         cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [SB-1:0]           left_horizontal_raw_i = '0;
  logic [SB-1:0]           left_vertical_raw_i = '0;
  logic [SB-1:0]           right_horizontal_raw_i = '0;
  logic [SB-1:0]           right_vertical_raw_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] left_x_o;
  logic signed [OUT_W-1:0] left_y_o;
  logic                    left_pressed_o;
  logic signed [OUT_W-1:0] right_x_o;
  logic signed [OUT_W-1:0] right_y_o;
  logic                    right_pressed_o;

  stick_scoreboard sb;
  bit idle_on = 1'b0;
  bit long_hold = 1'b0;
  int idle_count = 0;

  always #2 clk_i = ~clk_i;

  joystick_axis_calibrator #(.SAMPLE_BITS(SB), .FRAC_BITS(FRAC)) uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .left_horizontal_raw_i, .left_vertical_raw_i,
    .right_horizontal_raw_i, .right_vertical_raw_i,
    .out_valid_o, .out_stall_i,
    .left_x_o, .left_y_o, .left_pressed_o,
    .right_x_o, .right_y_o, .right_pressed_o
  );

  always @(posedge clk_i) begin : monitor
    pad_word_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        sb.apply_reg(cfg_index_i, cfg_data_i);
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_word(left_horizontal_raw_i, left_vertical_raw_i,
                     right_horizontal_raw_i, right_vertical_raw_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {left_x_o, left_y_o, left_pressed_o, right_x_o, right_y_o, right_pressed_o};
        sb.check_word(got);
        moved = 1'b1;
      end
      if (moved) idle_count = 0;
      else idle_count++;
    end
  end

  initial begin : watchdog
    while (idle_count < IDLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  // output side: random stall bursts and one long hold-off
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(logic [SB-1:0] lh, logic [SB-1:0] lv,
                           logic [SB-1:0] rh, logic [SB-1:0] rv);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i             <= 1'b1;
    left_horizontal_raw_i  <= lh;
    left_vertical_raw_i    <= lv;
    right_horizontal_raw_i <= rh;
    right_vertical_raw_i   <= rv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic post_reg(logic [CFG_IDX_W-1:0] idx, logic [3*SB-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // spare upper bits carry noise so that field masking is exercised
  task automatic set_config(logic [3*SB-1:0] lh, logic [3*SB-1:0] lv,
                            logic [3*SB-1:0] rh, logic [3*SB-1:0] rv, logic byp,
                            logic [DZ_W-1:0] dz, logic [SB-1:0] thr, bit stray);
    if (stray) post_reg(CFG_NONE, 30'($urandom));
    post_reg(CFG_LEFT_H, lh);
    post_reg(CFG_LEFT_V, lv);
    post_reg(CFG_RIGHT_H, rh);
    post_reg(CFG_RIGHT_V, rv);
    post_reg(CFG_BYPASS, {29'($urandom), byp});
    post_reg(CFG_DEAD_ZONE, {18'($urandom), dz});
    post_reg(CFG_PRESS_THR, {20'($urandom), thr});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SB-1:0] pick_near(logic [SB-1:0] ctr);
    int v;
    v = int'(ctr) + int'($urandom_range(0, 48)) - 24;
    if (v < 0) v = 0;
    if (v > (1 << SB) - 1) v = (1 << SB) - 1;
    return SB'(v);
  endfunction

  function automatic logic [SB-1:0] pick_raw(logic [SB-1:0] ctr);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sb.press_thr;
      3: return sb.press_thr + 1'b1;
      4, 5, 6: return pick_near(ctr);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [SB-1:0] pick_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return SB'(1);
      default: return SB'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [SB-1:0]   r [4];
    logic [3*SB-1:0] c [4];
    logic [DZ_W-1:0] dz;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // reset settings: extremes, zero offset, dead zone, press boundary
    send_word(0, 0, 0, 0);
    send_word(1023, 1023, 1023, 1023);
    send_word(512, 512, 512, 512);
    send_word(515, 510, 508, 514);
    send_word(530, 512, 512, 600);
    send_word(512, 900, 512, 901);
    send_word(0, 1023, 1023, 0);
    wait_idle();

    // zero and unit spans saturate, dead zone off, lowest threshold
    set_config({10'd0, 10'd0, 10'd512}, {10'd1, 10'd1, 10'd0},
               {10'd1023, 10'd1023, 10'd1023}, {10'd0, 10'd1023, 10'd1023},
               1'b0, 12'd0, 10'd0, 1'b1);
    send_word(0, 0, 0, 0);
    send_word(1023, 1023, 1023, 1023);
    send_word(512, 513, 511, 1);
    send_word(1, 0, 1022, 1023);
    send_word(513, 1, 0, 0);
    wait_idle();

    // bypass with extreme centres, widest dead zone, highest threshold
    set_config({10'd511, 10'd400, 10'd0}, CAL_DEFAULT, CAL_DEFAULT,
               {10'd300, 10'd300, 10'd1023}, 1'b1, 12'd4095, 10'd1023, 1'b0);
    send_word(0, 0, 0, 0);
    send_word(1023, 1023, 1023, 1023);
    send_word(512, 512, 512, 512);
    send_word(0, 1023, 1023, 0);
    wait_idle();

    // widest dead zone with scaling
    set_config(CAL_DEFAULT, CAL_DEFAULT, CAL_DEFAULT, CAL_DEFAULT,
               1'b0, 12'd4095, 10'd1023, 1'b0);
    send_word(512, 512, 512, 512);
    send_word(600, 600, 600, 600);
    send_word(400, 512, 512, 700);
    send_word(0, 0, 1023, 1023);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph != 7) && (ph % 3 != 1);
      foreach (c[i]) c[i] = {pick_field(), pick_field(), pick_field()};
      case ($urandom_range(0, 3))
        0: dz = '0;
        1: dz = '1;
        2: dz = DZ_W'($urandom_range(0, 400));
        default: dz = DZ_W'($urandom);
      endcase
      set_config(c[0], c[1], c[2], c[3], $urandom_range(0, 3) == 0, dz, pick_field(),
                 $urandom_range(0, 1) == 1);
      if (ph == 3) long_hold = 1'b1;
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) begin
          foreach (r[i]) r[i] = pick_near(sb.cal[i][SB-1:0]);
        end else begin
          foreach (r[i]) r[i] = pick_raw(sb.cal[i][SB-1:0]);
        end
        send_word(r[0], r[1], r[2], r[3]);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/jac_pkg.sv
hw/rtl/jac_front.sv
hw/rtl/jac_div_step.sv
hw/rtl/jac_result.sv
hw/rtl/joystick_axis_calibrator.sv
sim/tb.sv
